/* rtl/ffba_pkg.sv */
// Package for the first-fit block allocator: default sizes, status codes and widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;
   localparam int POOL_BYTES_DEF   = 16384;
   localparam int HEADER_BYTES_DEF = 24;
   localparam int MAX_SEGMENTS_DEF = 64;
   localparam int OFF_W  = 15;
   localparam int SIZE_W = 14;
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_NOFIT = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_NOSEG = 2'd3;
   typedef struct packed {
      logic              free;
      logic [OFF_W-1:0]  offset;
      logic [SIZE_W-1:0] size;
   } seg_type;
endpackage
`default_nettype wire

/* rtl/ffba_if.sv */
// Valid/ready channel interfaces for requests and responses.
// Depends on ffba_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface ffba_req_if import ffba_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              mode;
   logic [SIZE_W-1:0] size_req;
   logic [OFF_W-1:0]  address;
   modport source (output valid, mode, size_req, address, input ready);
   modport sink (input valid, mode, size_req, address, output ready);
endinterface

interface ffba_rsp_if import ffba_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [1:0]       status;
   logic [OFF_W-1:0] offset;
   modport source (output valid, status, offset, input ready);
   modport sink (input valid, status, offset, output ready);
endinterface
`default_nettype wire

/* rtl/first_fit_block_allocator.sv */
// Top level of the first-fit block allocator: segment memory and its sequencer.
// Depends on ffba_pkg and the channel interfaces in ffba_if.
`timescale 1ns / 1ps
`default_nettype none
// One request beat is taken at a time. The response beat follows after a walk of the
// segment table through its single read port, one entry in S_RD and S_CHK at a time. An
// allocate scans until it finds a fit. On a split it moves every later entry up by one.
// A release looks the address up; if it is found, it then runs a merge pass over the
// whole table and writes the compacted table back. The quickest response is to a release
// address out of range, which skips the walk; the slowest is to a release of the last
// entry of a full table. The table memory needs no clearing pass: entries beyond the
// count are never used.
module first_fit_block_allocator import ffba_pkg::*; #(
   parameter int POOL_BYTES   = POOL_BYTES_DEF,
   parameter int HEADER_BYTES = HEADER_BYTES_DEF,
   parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
) (
   input wire logic    clock,
   input wire logic    reset,
   ffba_req_if.sink    req,
   ffba_rsp_if.source  rsp
);
   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int SW = 17;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD    = 4'd1;
   localparam logic [3:0] S_CHK   = 4'd2;
   localparam logic [3:0] S_SHRD  = 4'd3;
   localparam logic [3:0] S_SHWR  = 4'd4;
   localparam logic [3:0] S_SPLIT = 4'd5;
   localparam logic [3:0] S_MRD   = 4'd6;
   localparam logic [3:0] S_MCHK  = 4'd7;
   localparam logic [3:0] S_MFIN  = 4'd8;
   localparam logic [3:0] S_RESP  = 4'd9;

   seg_type mem [MAX_SEGMENTS];
   seg_type rdata_ff;
   logic [IW-1:0] raddr;
   logic          wen;
   logic [IW-1:0] waddr;
   seg_type       wdata;

   logic [3:0]        state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     widx_ff, widx_in;
   logic              mode_ff, mode_in;
   logic [SIZE_W-1:0] req_ff, req_in;
   logic [OFF_W-1:0]  addr_ff, addr_in;
   logic [1:0]        status_ff, status_in;
   logic [OFF_W-1:0]  off_ff, off_in;
   seg_type           acc_ff, acc_in;
   logic              have_ff, have_in;
   logic              seg0_ff, seg0_in;

   logic [SW-1:0] need;
   logic [SW-1:0] merged;

   always_ff @(posedge clock) begin
      if (wen) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   // Reset entry is held aside until the first write to entry zero.
   seg_type rd_seg;
   always_comb begin
      rd_seg = rdata_ff;
      if (!seg0_ff && idx_ff == CW'(1)) begin
         rd_seg.free   = 1'b1;
         rd_seg.offset = '0;
         rd_seg.size   = SIZE_W'(POOL_BYTES - HEADER_BYTES);
      end
   end

   assign need   = SW'(req_ff) + SW'(HEADER_BYTES);
   assign merged = SW'(acc_ff.size) + SW'(rd_seg.size) + SW'(HEADER_BYTES);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      widx_in   = widx_ff;
      mode_in   = mode_ff;
      req_in    = req_ff;
      addr_in   = addr_ff;
      status_in = status_ff;
      off_in    = off_ff;
      acc_in    = acc_ff;
      have_in   = have_ff;
      seg0_in   = seg0_ff;
      raddr     = idx_ff[IW-1:0];
      wen       = 1'b0;
      waddr     = idx_ff[IW-1:0];
      wdata     = rd_seg;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               mode_in = req.mode;
               req_in  = req.size_req;
               addr_in = req.address;
               idx_in  = '0;
               off_in  = '0;
               if (req.mode && 32'(req.address) >= POOL_BYTES) begin
                  status_in = ST_RANGE;
                  state_in  = S_RESP;
               end else begin
                  status_in = req.mode ? ST_NOSEG : ST_NOFIT;
                  state_in  = S_RD;
               end
            end
         end
         S_RD: begin
            if (idx_ff >= count_ff) begin
               state_in = S_RESP;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            waddr = IW'(idx_ff - CW'(1));
            state_in = S_RD;
            if (mode_ff) begin
               if (rd_seg.offset == addr_ff) begin
                  wen        = 1'b1;
                  wdata.free = 1'b1;
                  if (idx_ff == CW'(1)) seg0_in = 1'b1;
                  status_in  = ST_OK;
                  off_in     = addr_ff;
                  idx_in     = '0;
                  widx_in    = '0;
                  have_in    = 1'b0;
                  state_in   = S_MRD;
               end
            end else if (rd_seg.free) begin
               if (rd_seg.size == req_ff) begin
                  wen        = 1'b1;
                  wdata.free = 1'b0;
                  if (idx_ff == CW'(1)) seg0_in = 1'b1;
                  status_in  = ST_OK;
                  off_in     = rd_seg.offset;
                  state_in   = S_RESP;
               end else if (SW'(rd_seg.size) > need && count_ff < CW'(MAX_SEGMENTS)) begin
                  wen        = 1'b1;
                  wdata.free = 1'b0;
                  wdata.size = req_ff;
                  if (idx_ff == CW'(1)) seg0_in = 1'b1;
                  status_in  = ST_OK;
                  off_in     = rd_seg.offset;
                  acc_in.free   = 1'b1;
                  acc_in.offset = rd_seg.offset + OFF_W'(need);
                  acc_in.size   = rd_seg.size - SIZE_W'(need);
                  widx_in  = idx_ff;
                  idx_in   = count_ff - CW'(1);
                  state_in = S_SHRD;
               end
            end
         end
         S_SHRD: begin
            if (idx_ff < widx_ff) begin
               state_in = S_SPLIT;
            end else begin
               state_in = S_SHWR;
            end
         end
         S_SHWR: begin
            wen      = 1'b1;
            waddr    = IW'(idx_ff + CW'(1));
            wdata    = rdata_ff;
            idx_in   = idx_ff - CW'(1);
            state_in = S_SHRD;
         end
         S_SPLIT: begin
            wen      = 1'b1;
            waddr    = widx_ff[IW-1:0];
            wdata    = acc_ff;
            count_in = count_ff + CW'(1);
            state_in = S_RESP;
         end
         S_MRD: begin
            if (idx_ff >= count_ff) begin
               state_in = S_MFIN;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_MCHK;
            end
         end
         S_MCHK: begin
            waddr = widx_ff[IW-1:0];
            state_in = S_MRD;
            if (!have_ff) begin
               acc_in  = rd_seg;
               have_in = 1'b1;
            end else if (acc_ff.free && rd_seg.free) begin
               acc_in.size = SIZE_W'(merged);
            end else begin
               wen     = 1'b1;
               wdata   = acc_ff;
               if (widx_ff == '0) seg0_in = 1'b1;
               widx_in = widx_ff + CW'(1);
               acc_in  = rd_seg;
            end
         end
         S_MFIN: begin
            wen      = 1'b1;
            waddr    = widx_ff[IW-1:0];
            wdata    = acc_ff;
            if (widx_ff == '0) seg0_in = 1'b1;
            count_in = widx_ff + CW'(1);
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp.ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= CW'(1);
         seg0_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         seg0_ff  <= seg0_in;
      end
      idx_ff    <= idx_in;
      widx_ff   <= widx_in;
      mode_ff   <= mode_in;
      req_ff    <= req_in;
      addr_ff   <= addr_in;
      status_ff <= status_in;
      off_ff    <= off_in;
      acc_ff    <= acc_in;
      have_ff   <= have_in;
   end

   assign req.ready  = (state_ff == S_IDLE);
   assign rsp.valid  = (state_ff == S_RESP);
   assign rsp.status = status_ff;
   assign rsp.offset = (status_ff == ST_OK) ? off_ff : '0;

`ifndef NO_ASSERTIONS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff >= CW'(1) && count_ff <= CW'(MAX_SEGMENTS))
      else $error("segment count out of range");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.status))
      else $error("response changed while stalled");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid))
      else $error("ready while response pending");
   a_split_grow: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SPLIT |=> count_ff == $past(count_ff) + CW'(1))
      else $error("split did not grow the table");
`endif
endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for first_fit_block_allocator: drives allocate and release beats,
// predicts each response from its own segment table and compares status and offset.
// Depends on ffba_pkg, the channel interfaces in ffba_if and the allocator RTL.
`timescale 1ns / 1ps
module tb_top;
   import ffba_pkg::*;

   localparam int POOL = POOL_BYTES_DEF;
   localparam int HDR = HEADER_BYTES_DEF;
   localparam int NSEG = MAX_SEGMENTS_DEF;
   localparam int N_RANDOM = 1000;
   localparam int CYCLE_LIMIT = 1500000;
   localparam bit MODE_ALLOC = 1'b0;
   localparam bit MODE_FREE = 1'b1;

   typedef struct {
      bit [OFF_W-1:0] offset;
      bit [SIZE_W:0] size;
      bit is_free;
   } segment_t;

   typedef struct {
      bit [1:0] status;
      bit [OFF_W-1:0] offset;
   } outcome_t;

   typedef struct {
      bit mode;
      bit [SIZE_W-1:0] size_req;
      bit [OFF_W-1:0] address;
      bit typed;
      bit [1:0] status;
      bit [OFF_W-1:0] offset;
   } stim_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   ffba_req_if req ();
   ffba_rsp_if rsp ();

   first_fit_block_allocator i_dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   always #2 clock = ~clock;

   segment_t seg_table[NSEG];
   int seg_count;
   outcome_t pending_responses[$];
   bit [OFF_W-1:0] used_offsets[$];
   int errors = 0;
   int checked = 0;
   int n_alloc = 0;
   int n_free = 0;
   int cycles = 0;
   bit quiet_rx = 1'b0;
   bit hold_rx = 1'b0;

   function automatic void table_reset();
      seg_count = 1;
      seg_table[0].offset = '0;
      seg_table[0].size = (SIZE_W+1)'(POOL - HDR);
      seg_table[0].is_free = 1'b1;
   endfunction

   function automatic void merge_free_neighbours();
      int i;
      i = 0;
      while (i + 1 < seg_count) begin
         if (seg_table[i].is_free && seg_table[i+1].is_free) begin
            seg_table[i].size = (SIZE_W+1)'(seg_table[i].size + seg_table[i+1].size + HDR);
            for (int k = i + 1; k < seg_count - 1; k++) seg_table[k] = seg_table[k+1];
            seg_count--;
         end else begin
            i++;
         end
      end
   endfunction

   function automatic outcome_t predict_allocation(bit mode, bit [SIZE_W-1:0] sz,
                                                   bit [OFF_W-1:0] addr);
      outcome_t r;
      int s;
      r.status = ST_NOFIT;
      r.offset = '0;
      if (mode == MODE_ALLOC) begin
         for (int i = 0; i < seg_count; i++) begin
            if (!seg_table[i].is_free) continue;
            s = seg_table[i].size;
            if (s == sz) begin
               seg_table[i].is_free = 1'b0;
               r.status = ST_OK;
               r.offset = seg_table[i].offset;
               break;
            end
            if (s > sz + HDR && seg_count < NSEG) begin
               for (int k = seg_count; k > i + 1; k--) seg_table[k] = seg_table[k-1];
               seg_table[i+1].offset = OFF_W'(seg_table[i].offset + HDR + sz);
               seg_table[i+1].size = (SIZE_W+1)'(s - sz - HDR);
               seg_table[i+1].is_free = 1'b1;
               seg_count++;
               seg_table[i].size = (SIZE_W+1)'(sz);
               seg_table[i].is_free = 1'b0;
               r.status = ST_OK;
               r.offset = seg_table[i].offset;
               break;
            end
         end
      end else if (addr >= POOL) begin
         r.status = ST_RANGE;
      end else begin
         r.status = ST_NOSEG;
         for (int i = 0; i < seg_count; i++) begin
            if (seg_table[i].offset == addr) begin
               seg_table[i].is_free = 1'b1;
               merge_free_neighbours();
               r.status = ST_OK;
               r.offset = addr;
               break;
            end
         end
      end
      return r;
   endfunction

   task automatic send_beat(bit mode, bit [SIZE_W-1:0] sz, bit [OFF_W-1:0] addr,
                            output outcome_t predicted);
      while (!quiet_rx && $urandom_range(99) < 8) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.mode <= mode;
      req.size_req <= sz;
      req.address <= addr;
      do @(posedge clock); while (!req.ready);
      predicted = predict_allocation(mode, sz, addr);
      pending_responses.push_back(predicted);
      if (mode == MODE_ALLOC) n_alloc++; else n_free++;
      if (mode == MODE_ALLOC && predicted.status == ST_OK) used_offsets.push_back(predicted.offset);
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycles);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (pending_responses.size() == 0) begin
               $display("%0t: response beat with nothing expected: status %0d offset %0d",
                        $time, rsp.status, rsp.offset);
               errors++;
            end else begin
               outcome_t e;
               e = pending_responses.pop_front();
               checked++;
               if (rsp.status !== e.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, e.status, rsp.status);
                  errors++;
               end
               if (rsp.offset !== e.offset) begin
                  $display("%0t: offset expected %0d actual %0d", $time, e.offset, rsp.offset);
                  errors++;
               end
            end
         end
         rsp.ready <= hold_rx ? 1'b0 : (quiet_rx ? 1'b1 : ($urandom_range(99) >= 8));
      end
   end

   initial begin
      int hold_cycles;
      wait (n_alloc + n_free > 40);
      @(posedge clock);
      hold_rx <= 1'b1;
      hold_cycles = 0;
      while (hold_cycles < 3000) begin
         @(posedge clock);
         hold_cycles++;
      end
      hold_rx <= 1'b0;
   end

   stim_row_t directed[] = '{
      '{MODE_FREE, 14'd0, 15'd16384, 1'b1, ST_RANGE, 15'd0},
      '{MODE_FREE, 14'd0, 15'd32767, 1'b1, ST_RANGE, 15'd0},
      '{MODE_FREE, 14'd0, 15'd5, 1'b1, ST_NOSEG, 15'd0},
      '{MODE_ALLOC, 14'd16383, 15'd0, 1'b1, ST_NOFIT, 15'd0},
      '{MODE_ALLOC, 14'd16360, 15'd0, 1'b1, ST_OK, 15'd0},
      '{MODE_ALLOC, 14'd0, 15'd0, 1'b1, ST_NOFIT, 15'd0},
      '{MODE_FREE, 14'd0, 15'd0, 1'b1, ST_OK, 15'd0},
      '{MODE_FREE, 14'd0, 15'd0, 1'b1, ST_OK, 15'd0},
      '{MODE_ALLOC, 14'd0, 15'd0, 1'b1, ST_OK, 15'd0},
      '{MODE_ALLOC, 14'd100, 15'd0, 1'b0, ST_OK, 15'd0},
      '{MODE_ALLOC, 14'd16024, 15'd0, 1'b0, ST_OK, 15'd0},
      '{MODE_FREE, 14'd0, 15'd24, 1'b0, ST_OK, 15'd0},
      '{MODE_ALLOC, 14'd100, 15'd0, 1'b0, ST_OK, 15'd0},
      '{MODE_FREE, 14'd0, 15'd16383, 1'b0, ST_OK, 15'd0},
      '{MODE_FREE, 14'd0, 15'd0, 1'b0, ST_OK, 15'd0},
      '{MODE_FREE, 14'd0, 15'd24, 1'b0, ST_OK, 15'd0},
      '{MODE_FREE, 14'd0, 15'd148, 1'b0, ST_OK, 15'd0}
   };

   initial begin
      outcome_t p;
      int drained;
      bit [SIZE_W-1:0] sz;
      bit [OFF_W-1:0] addr;
      int pick;
      req.valid = 1'b0;
      req.mode = 1'b0;
      req.size_req = '0;
      req.address = '0;
      table_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[n]) begin
         send_beat(directed[n].mode, directed[n].size_req, directed[n].address, p);
         if (directed[n].typed && (p.status != directed[n].status ||
                                   p.offset != directed[n].offset)) begin
            $display("%0t: directed row %0d predicts status %0d offset %0d, table says %0d %0d",
                     $time, n, p.status, p.offset, directed[n].status, directed[n].offset);
            errors++;
         end
      end

      for (int n = 0; n < N_RANDOM; n++) begin
         quiet_rx = (n >= 400 && n < 550);
         pick = $urandom_range(99);
         sz = (pick < 70) ? SIZE_W'($urandom_range(200)) : SIZE_W'($urandom);
         if ($urandom_range(99) < 25) sz = 14'h3FFF;
         addr = OFF_W'($urandom);
         if ($urandom_range(99) < 50 && seg_count > 0)
            addr = seg_table[$urandom_range(seg_count - 1)].offset;
         else if ($urandom_range(99) < 50 && used_offsets.size() > 0)
            addr = used_offsets[$urandom_range(used_offsets.size() - 1)];
         if ($urandom_range(99) < 10) addr = 15'h7FFF;
         send_beat(($urandom_range(99) < 55) ? MODE_ALLOC : MODE_FREE, sz, addr, p);
      end
      quiet_rx = 1'b0;
      req.valid <= 1'b0;

      while (pending_responses.size() != 0) @(posedge clock);
      drained = 0;
      while (drained < 3 * NSEG + 20) begin
         @(posedge clock);
         drained++;
      end
      $display("Covered %0d allocate and %0d release beats; %0d responses compared.",
               n_alloc, n_free, checked);
      $display("Final table held %0d segments.", seg_count);
      if (errors == 0 && pending_responses.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule
